/* rtl/ewd_pkg.sv */
// ----------------------------------------------------------------------------
// ewd_pkg
// shared types and constants of the extraction word deframer
// ----------------------------------------------------------------------------
package ewd_pkg;

  localparam int unsigned QUEUES = 2;
  localparam int unsigned QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned BYTES_W = 14;
  localparam int unsigned PORT_W  = 4;
  localparam int unsigned VLAN_W  = 12;
  localparam int unsigned WBYTE_W = 3;

  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  localparam logic [WORD_W-1:0] CODE_BASE      = 32'h8000_0000;
  localparam logic [WORD_W-1:0] CODE_NOT_READY = 32'h8000_0007;

  localparam logic [2:0] CODE_END4   = 3'd0;
  localparam logic [2:0] CODE_END3   = 3'd1;
  localparam logic [2:0] CODE_END2   = 3'd2;
  localparam logic [2:0] CODE_END1   = 3'd3;
  localparam logic [2:0] CODE_PRUNED = 3'd4;
  localparam logic [2:0] CODE_ABORT  = 3'd5;

  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OPTR_W    = $clog2(OUT_DEPTH);
  localparam int unsigned OCNT_W    = $clog2(OUT_DEPTH + 1);

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 1;
  localparam int unsigned OUT_FIELD_W = WORD_W + WBYTE_W + PORT_W + VLAN_W + BYTES_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W = 3;

  typedef struct packed {
    logic [2:0]         phase;
    logic [2:0]         pending;
    logic [BYTES_W-1:0] total;
    logic [PORT_W-1:0]  port;
    logic [VLAN_W-1:0]  vlan;
  } qstate_t;

  typedef struct packed {
    logic               queue;
    logic [WORD_W-1:0]  data_word;
    logic [WBYTE_W-1:0] word_bytes;
    logic               last;
    logic               aborted;
    logic               pruned;
    logic [PORT_W-1:0]  source_port;
    logic [VLAN_W-1:0]  vlan_id;
    logic [BYTES_W-1:0] frame_bytes;
  } result_t;

endpackage

/* rtl/ewd_out_fifo.sv */
// ----------------------------------------------------------------------------
// ewd_out_fifo
// small result queue between the state update stage and the output port
// ----------------------------------------------------------------------------
module ewd_out_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ewd_pkg::result_t       push_data_i,
  input  logic                   pop_i,
  output logic                   valid_o,
  output ewd_pkg::result_t       head_o,
  output logic [ewd_pkg::OCNT_W-1:0] level_o
);
  import ewd_pkg::*;

  result_t           entry_q [OUT_DEPTH];
  logic [OPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign do_pop  = pop_i && (cnt_q != '0);
  assign valid_o = (cnt_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign level_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + OPTR_W'(1);
      end
      case ({push_i, do_pop})
        2'b10:   cnt_q <= cnt_q + OCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - OCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

/* rtl/extraction_word_deframer_unit.sv */
// ----------------------------------------------------------------------------
// extraction_word_deframer_unit
// per-queue deframing of words read from the cpu extraction queues
// ----------------------------------------------------------------------------
// Takes one word per clock unless held back, and keeps the deframing state of
// each queue in a small state memory. A word is accepted every cycle as long
// as the four-entry result queue holds at most two results, counting a word
// in the update stage as one, so the queue never runs full. The state memory
// read is registered at the edge that accepts the word; the next cycle
// updates, writes back and pushes the result into the output queue, which
// offers it on the output. A word that follows right behind another on the
// same queue sees the fresh state through a forwarding register. Header
// words, code words and not-ready words give no result; every data word
// gives one result with the running byte count.
// ----------------------------------------------------------------------------
module extraction_word_deframer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [ewd_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,  // raw_word
  input  logic [ewd_pkg::IN_TUSER_W-1:0]     s_axis_tuser_i,  // queue_index
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // data_word, word_bytes, source_port, vlan_id, frame_bytes, zero pad
  output logic [ewd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic [ewd_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o,  // out_queue, aborted, pruned
  output logic                               m_axis_tlast_o
);
  import ewd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_HDR2 = 3'd2,
    PH_HDR3 = 3'd3,
    PH_DATA = 3'd4,
    PH_CODE = 3'd5
  } phase_e;

  // input stage
  logic              in_fire;
  logic [QIDX_W-1:0] in_idx;

  // state memory
  qstate_t           state_mem [QUEUES];
  logic [QUEUES-1:0] written_q;
  qstate_t           rd_data_q;
  logic              rd_written_q;

  // update stage
  logic              s1_vld_q;
  logic [QIDX_W-1:0] s1_idx_q;
  logic              s1_queue_q;
  logic [WORD_W-1:0] s1_word_q;
  logic              fwd_q;
  qstate_t           fwd_data_q;

  qstate_t           cur;
  qstate_t           nxt;
  logic              res_vld;
  result_t           res;
  logic [BYTES_W:0]  sum;

  // output queue
  logic              out_vld;
  result_t           out_head;
  logic [OCNT_W-1:0] out_level;
  logic [OCNT_W:0]   inflight;

  assign in_idx   = QIDX_W'(QUEUES > 1 ? s_axis_tuser_i[0] : 1'b0);
  assign inflight = (OCNT_W + 1)'(out_level) + (OCNT_W + 1)'(s1_vld_q);
  assign s_axis_tready_o = (inflight <= (OCNT_W + 1)'(OUT_DEPTH - 2));
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      state_mem[s1_idx_q] <= nxt;
    end
    if (in_fire) begin
      rd_data_q    <= state_mem[in_idx];
      rd_written_q <= written_q[in_idx];
      s1_idx_q     <= in_idx;
      s1_queue_q   <= s_axis_tuser_i[0];
      s1_word_q    <= s_axis_tdata_i;
    end
    fwd_data_q <= nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      s1_vld_q  <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      if (s1_vld_q) begin
        written_q[s1_idx_q] <= 1'b1;
      end
      s1_vld_q <= in_fire;
      fwd_q    <= in_fire && s1_vld_q && (s1_idx_q == in_idx);
    end
  end

  always_comb begin
    if (fwd_q) begin
      cur = fwd_data_q;
    end else if (rd_written_q) begin
      cur = rd_data_q;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    nxt             = cur;
    res_vld         = 1'b0;
    res.queue       = s1_queue_q;
    res.data_word   = s1_word_q;
    res.word_bytes  = WBYTE_W'(4);
    res.last        = 1'b0;
    res.aborted     = 1'b0;
    res.pruned      = 1'b0;
    res.source_port = cur.port;
    res.vlan_id     = cur.vlan;
    res.frame_bytes = '0;
    sum             = '0;
    case (phase_e'(cur.phase))
      PH_HDR1: begin
        nxt.phase = PH_HDR2;
      end
      PH_HDR2: begin
        nxt.port  = s1_word_q[14:11];
        nxt.phase = PH_HDR3;
      end
      PH_HDR3: begin
        nxt.vlan  = s1_word_q[11:0];
        nxt.phase = PH_DATA;
      end
      PH_DATA: begin
        if (s1_word_q == CODE_NOT_READY) begin
          nxt = cur;
        end else if (s1_word_q[WORD_W-1:3] == CODE_BASE[WORD_W-1:3]) begin
          nxt.pending = s1_word_q[2:0];
          nxt.phase   = PH_CODE;
        end else begin
          res_vld = 1'b1;
        end
      end
      PH_CODE: begin
        nxt.phase = PH_DATA;
        res_vld   = 1'b1;
        case (cur.pending)
          CODE_END4: res.last = 1'b1;
          CODE_END3: begin
            res.last       = 1'b1;
            res.word_bytes = WBYTE_W'(3);
          end
          CODE_END2: begin
            res.last       = 1'b1;
            res.word_bytes = WBYTE_W'(2);
          end
          CODE_END1: begin
            res.last       = 1'b1;
            res.word_bytes = WBYTE_W'(1);
          end
          CODE_PRUNED: begin
            res.last   = 1'b1;
            res.pruned = 1'b1;
          end
          CODE_ABORT: begin
            res.last       = 1'b1;
            res.aborted    = 1'b1;
            res.word_bytes = '0;
            res.data_word  = '0;
          end
          default: res.last = 1'b0;
        endcase
      end
      default: begin
        nxt.total = '0;
        nxt.phase = PH_HDR1;
      end
    endcase
    if (res_vld) begin
      sum = (BYTES_W + 1)'(cur.total) + (BYTES_W + 1)'(res.word_bytes);
      if (res.aborted) begin
        nxt.total = '0;
      end else if (sum[BYTES_W]) begin
        nxt.total = BYTES_MAX;
      end else begin
        nxt.total = sum[BYTES_W-1:0];
      end
      if (res.last) begin
        nxt.phase = PH_HDR0;
      end
    end
    res.frame_bytes = nxt.total;
  end

  ewd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_vld_q && res_vld),
    .push_data_i (res),
    .pop_i       (m_axis_tready_i),
    .valid_o     (out_vld),
    .head_o      (out_head),
    .level_o     (out_level)
  );

  assign m_axis_tvalid_o = out_vld;
  assign m_axis_tlast_o  = out_head.last;
  assign m_axis_tuser_o  = {out_head.pruned, out_head.aborted, out_head.queue};
  assign m_axis_tdata_o  = {(OUT_TDATA_W - OUT_FIELD_W)'(0),
                            out_head.frame_bytes, out_head.vlan_id,
                            out_head.source_port, out_head.word_bytes,
                            out_head.data_word};

endmodule

/* tb/deframer_checker.sv */
// ----------------------------------------------------------------------------
// deframer_checker
// predicts and checks the results of the extraction word deframer
// ----------------------------------------------------------------------------
// Watches both stream channels. Every accepted input word runs through a
// per-queue model of the header, data and code-word handling. Each data word
// yields one expected result. Results leaving the block are decoded from
// tdata, tuser and tlast and compared in order against the expected ones.
// ----------------------------------------------------------------------------
module deframer_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [ewd_pkg::IN_TDATA_W-1:0]     in_data_i,
  input  logic [ewd_pkg::IN_TUSER_W-1:0]     in_user_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [ewd_pkg::OUT_TDATA_W-1:0]    out_data_i,
  input  logic [ewd_pkg::OUT_TUSER_W-1:0]    out_user_i,
  input  logic                               out_last_i,
  output int                                 errors_o,
  output int                                 outstanding_o
);
  import ewd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEAD0,
    PH_HEAD1,
    PH_HEAD2,
    PH_HEAD3,
    PH_BODY,
    PH_AFTER_CODE
  } phase_e;

  localparam int unsigned OFF_WBYTES = WORD_W;
  localparam int unsigned OFF_PORT   = OFF_WBYTES + WBYTE_W;
  localparam int unsigned OFF_VLAN   = OFF_PORT + PORT_W;
  localparam int unsigned OFF_TOTAL  = OFF_VLAN + VLAN_W;

  phase_e             phase_q [QUEUES];
  logic [2:0]         pend_q  [QUEUES];
  logic [BYTES_W-1:0] total_q [QUEUES];
  logic [PORT_W-1:0]  port_q  [QUEUES];
  logic [VLAN_W-1:0]  vlan_q  [QUEUES];

  result_t expected_words[$];
  result_t predicted;
  result_t seen;
  result_t oldest;

  function automatic bit deframe_word(input logic qin, input logic [WORD_W-1:0] w,
                                      output result_t r);
    int unsigned        qi;
    logic [WBYTE_W-1:0] nbytes;
    logic [BYTES_W:0]   sum;
    logic               fin;
    logic               abort;
    logic               prune;
    logic [WORD_W-1:0]  data;
    qi     = qin % QUEUES;
    nbytes = 3'd4;
    fin    = 1'b0;
    abort  = 1'b0;
    prune  = 1'b0;
    data   = w;
    r      = '0;
    case (phase_q[qi])
      PH_HEAD1: begin
        phase_q[qi] = PH_HEAD2;
        return 1'b0;
      end
      PH_HEAD2: begin
        port_q[qi]  = w[14:11];
        phase_q[qi] = PH_HEAD3;
        return 1'b0;
      end
      PH_HEAD3: begin
        vlan_q[qi]  = w[11:0];
        phase_q[qi] = PH_BODY;
        return 1'b0;
      end
      PH_BODY: begin
        if (w == CODE_NOT_READY) return 1'b0;
        if (w >= CODE_BASE && w < CODE_NOT_READY) begin
          pend_q[qi]  = w[2:0];
          phase_q[qi] = PH_AFTER_CODE;
          return 1'b0;
        end
      end
      PH_AFTER_CODE: begin
        phase_q[qi] = PH_BODY;
        case (pend_q[qi])
          CODE_END4: fin = 1'b1;
          CODE_END3: begin
            fin    = 1'b1;
            nbytes = 3'd3;
          end
          CODE_END2: begin
            fin    = 1'b1;
            nbytes = 3'd2;
          end
          CODE_END1: begin
            fin    = 1'b1;
            nbytes = 3'd1;
          end
          CODE_PRUNED: begin
            fin   = 1'b1;
            prune = 1'b1;
          end
          CODE_ABORT: begin
            fin    = 1'b1;
            abort  = 1'b1;
            nbytes = 3'd0;
            data   = '0;
          end
          default: ;
        endcase
      end
      default: begin
        total_q[qi] = '0;
        phase_q[qi] = PH_HEAD1;
        return 1'b0;
      end
    endcase

    if (abort) begin
      total_q[qi] = '0;
    end else begin
      sum         = {1'b0, total_q[qi]} + (BYTES_W + 1)'(nbytes);
      total_q[qi] = (sum > {1'b0, BYTES_MAX}) ? BYTES_MAX : sum[BYTES_W-1:0];
    end
    if (fin) phase_q[qi] = PH_HEAD0;

    r.queue       = qin;
    r.data_word   = data;
    r.word_bytes  = nbytes;
    r.last        = fin;
    r.aborted     = abort;
    r.pruned      = prune;
    r.source_port = port_q[qi];
    r.vlan_id     = vlan_q[qi];
    r.frame_bytes = total_q[qi];
    return 1'b1;
  endfunction

  function automatic string show(input result_t r);
    return {$sformatf("q=%0d data=%h bytes=%0d last=%0b abort=%0b pruned=%0b ",
                      r.queue, r.data_word, r.word_bytes, r.last, r.aborted, r.pruned),
            $sformatf("port=%0d vlan=%0d total=%0d",
                      r.source_port, r.vlan_id, r.frame_bytes)};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUES; i++) begin
        phase_q[i] = PH_HEAD0;
        pend_q[i]  = '0;
        total_q[i] = '0;
        port_q[i]  = '0;
        vlan_q[i]  = '0;
      end
      expected_words.delete();
      errors_o      = 0;
      outstanding_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen.queue       = out_user_i[0];
        seen.aborted     = out_user_i[1];
        seen.pruned      = out_user_i[2];
        seen.last        = out_last_i;
        seen.data_word   = out_data_i[WORD_W-1:0];
        seen.word_bytes  = out_data_i[OFF_WBYTES +: WBYTE_W];
        seen.source_port = out_data_i[OFF_PORT +: PORT_W];
        seen.vlan_id     = out_data_i[OFF_VLAN +: VLAN_W];
        seen.frame_bytes = out_data_i[OFF_TOTAL +: BYTES_W];
        if (expected_words.size() == 0) begin
          if (errors_o < 10) $display("unexpected word: %s", show(seen));
          errors_o++;
        end else begin
          oldest = expected_words.pop_front();
          if (seen.queue !== oldest.queue || seen.data_word !== oldest.data_word ||
              seen.word_bytes !== oldest.word_bytes || seen.last !== oldest.last ||
              seen.aborted !== oldest.aborted || seen.pruned !== oldest.pruned ||
              seen.source_port !== oldest.source_port || seen.vlan_id !== oldest.vlan_id ||
              seen.frame_bytes !== oldest.frame_bytes) begin
            if (errors_o < 10) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected %s", show(oldest));
              $display("  actual   %s", show(seen));
            end
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (deframe_word(in_user_i[0], in_data_i, predicted)) begin
          expected_words.push_back(predicted);
        end
      end
      outstanding_o = expected_words.size();
    end
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the extraction word deframer
// ----------------------------------------------------------------------------
// Sends a short directed set of frames on both queues, then random frames,
// alone or interleaved across the two queues, mixed with stray and code
// words. Both channels idle at random, with stretches of full rate. The
// checker module predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import ewd_pkg::*;

  typedef struct packed {
    logic              q;
    logic [WORD_W-1:0] w;
  } queued_word_t;

  localparam logic [2:0] CODE_ESCAPE  = 3'd6;
  localparam int         RANDOM_WORDS = 1620;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic [IN_TUSER_W-1:0]  s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   m_tlast;
  bit                     calm     = 1'b0;
  int                     errors;
  int                     outstanding;

  always #5 clk_i = ~clk_i;

  extraction_word_deframer_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  deframer_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_tvalid),
    .in_ready_i    (s_tready),
    .in_data_i     (s_tdata),
    .in_user_i     (s_tuser),
    .out_valid_i   (m_tvalid),
    .out_ready_i   (m_tready),
    .out_data_i    (m_tdata),
    .out_user_i    (m_tuser),
    .out_last_i    (m_tlast),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [WORD_W-1:0] code_word(input logic [2:0] c);
    return {CODE_BASE[WORD_W-1:3], c};
  endfunction

  function automatic logic [WORD_W-1:0] any_code();
    return code_word(3'($urandom_range(0, 7)));
  endfunction

  function automatic logic [WORD_W-1:0] header_word();
    if ($urandom_range(0, 9) == 0) return any_code();
    return $urandom;
  endfunction

  function automatic void build_frame(input logic q, input int body,
                                      ref queued_word_t list[$]);
    int r;
    for (int i = 0; i < 4; i++) list.push_back({q, header_word()});
    for (int i = 0; i < body; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        list.push_back({q, CODE_NOT_READY});
      end else if (r < 16) begin
        list.push_back({q, code_word(CODE_ESCAPE)});
        list.push_back({q, ($urandom_range(0, 1) == 1) ? any_code() : 32'($urandom)});
      end else begin
        list.push_back({q, 32'($urandom)});
      end
    end
    if ($urandom_range(0, 99) < 15) list.push_back({q, CODE_NOT_READY});
    list.push_back({q, code_word(3'($urandom_range(0, 5)))});
    list.push_back({q, ($urandom_range(0, 4) == 0) ? any_code() : 32'($urandom)});
  endfunction

  always begin
    m_tready <= 1'b1;
    repeat ($urandom_range(1, 30)) @(posedge clk_i);
    if (!calm && rst_ni) begin
      int n;
      n = pick_gap();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic send_word(input logic q, input logic [WORD_W-1:0] w);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    s_tuser  <= q;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic send_list(ref queued_word_t list[$]);
    foreach (list[i]) send_word(list[i].q, list[i].w);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    queued_word_t frame_a[$];
    queued_word_t frame_b[$];
    queued_word_t mixed[$];
    int           r;
    int           n;
    int           random_sent;
    random_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // header words that look like codes, widest port and vlan, short end
    send_word(1'b0, CODE_NOT_READY);
    send_word(1'b0, code_word(CODE_ABORT));
    send_word(1'b0, 32'hFFFF_FFFF);
    send_word(1'b0, 32'hFFFF_FFFF);
    send_word(1'b0, 32'h0000_0000);
    send_word(1'b0, CODE_NOT_READY);
    send_word(1'b0, code_word(CODE_ESCAPE));
    send_word(1'b0, code_word(CODE_END1));
    send_word(1'b0, 32'h7FFF_FFFF);
    send_word(1'b0, code_word(CODE_END1));
    send_word(1'b0, 32'hFFFF_FFFF);
    // zero header, word just above the code range, pruned end on a code value
    for (int i = 0; i < 4; i++) send_word(1'b1, 32'h0000_0000);
    send_word(1'b1, 32'h8000_0008);
    send_word(1'b1, code_word(CODE_PRUNED));
    send_word(1'b1, CODE_NOT_READY);
    // aborted frame
    for (int i = 0; i < 4; i++) send_word(1'b0, $urandom);
    send_word(1'b0, 32'h1234_5678);
    send_word(1'b0, code_word(CODE_ABORT));
    send_word(1'b0, 32'hDEAD_BEEF);
    wait_drained();

    while (random_sent < RANDOM_WORDS) begin
      frame_a.delete();
      frame_b.delete();
      mixed.delete();
      calm = ($urandom_range(0, 9) == 0);
      r    = $urandom_range(0, 99);
      if (r < 65) begin
        build_frame(1'b0, $urandom_range(0, 12), frame_a);
        build_frame(1'b1, $urandom_range(0, 12), frame_b);
        while (frame_a.size() != 0 || frame_b.size() != 0) begin
          if (frame_b.size() == 0 || (frame_a.size() != 0 && $urandom_range(0, 1) == 0))
            mixed.push_back(frame_a.pop_front());
          else
            mixed.push_back(frame_b.pop_front());
        end
      end else if (r < 85) begin
        build_frame(1'($urandom_range(0, 1)), $urandom_range(0, 20), mixed);
      end else if (r < 96) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
          mixed.push_back({1'($urandom_range(0, 1)),
                           ($urandom_range(0, 9) < 3) ? any_code() : 32'($urandom)});
        end
      end else begin
        wait_drained();
      end
      send_list(mixed);
      random_sent += mixed.size();
    end

    calm = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
